// File: rtl/core/bmp_pkg.sv
// Shared types, header layout constants and helpers for the BMP stream decoder.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package bmp_pkg;

  // Fixed header layout (little-endian fields, byte offsets into the file)
  localparam int HEADER_BYTES = 54;
  localparam int OFS_SIG      = 'h0;
  localparam int OFS_FSIZE    = 'h2;
  localparam int OFS_OFFSET   = 'hA;
  localparam int OFS_WIDTH    = 'h12;
  localparam int OFS_HEIGHT   = 'h16;
  localparam int OFS_PLANES   = 'h1A;
  localparam int OFS_DEPTH    = 'h1C;
  localparam int OFS_DLEN     = 'h22;

  // First header index after every field is captured; length setup runs from here
  localparam int RECON_IDX    = OFS_DLEN + 4;

  localparam logic [15:0] SIG_VALUE = {8'h4D, 8'h42};  // 'M' high, 'B' low
  localparam logic [15:0] DEPTH24   = 16'd24;
  localparam logic [15:0] DEPTH32   = 16'd32;
  localparam logic [15:0] PLANES1   = 16'd1;
  localparam int          LINE_PAD  = 'h3;

  localparam int MAX_DIM_DEF     = 8192;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int TDATA_W         = 96;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_DATA   = 2'd2,
    PH_FIN    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    K_PIXEL  = 2'd0,
    K_HEADER = 2'd1,
    K_ERROR  = 2'd2,
    K_DONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    E_SIGNATURE    = 3'd0,
    E_PLANES       = 3'd1,
    E_DEPTH        = 3'd2,
    E_OFFSET       = 3'd3,
    E_SHORT_HEADER = 3'd4,
    E_SHORT_DATA   = 3'd5,
    E_TOO_LARGE    = 3'd6
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [12:0] column;
    logic [12:0] row;
    logic [13:0] image_width;
    logic [13:0] image_height;
    err_t        error_code;
    logic        last;
  } result_t;

  // One queue entry: a result plus an optional end-of-stream result behind it
  typedef struct packed {
    result_t head;
    logic    tail_valid;
    kind_t   tail_kind;
    err_t    tail_err;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Build a final result (error or done) with last set, the error code set for an error, and every other field zero
  function automatic result_t make_terminal(kind_t kind, err_t code);
    result_t r;
    r            = '0;
    r.kind       = kind;
    r.error_code = (kind == K_ERROR) ? code : E_SIGNATURE;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bmp_front.sv
// Front end: accepts file bytes, parses the header, tracks pixel position and
// builds queue entries. Depends on bmp_pkg.
`default_nettype none

module bmp_front #(
  parameter int MAX_DIM = bmp_pkg::MAX_DIM_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_eof,
  input  wire bmp_pkg::q_status_t q_status,
  output logic                    push,
  output bmp_pkg::entry_t         entry
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int LINE_W = DIM_W + 2;
  localparam int IMG_W = LINE_W + DIM_W;
  localparam int CMP_W = (IMG_W > 32) ? IMG_W : 32;

  bmp_pkg::phase_t phase, phase_next;
  logic [31:0] hdr_cnt, hdr_cnt_next;
  logic [31:0] data_cnt, data_cnt_next;
  logic [LINE_W-1:0] line_cnt, line_cnt_next;
  logic [12:0] column, column_next;
  logic [12:0] file_row, file_row_next;
  logic [23:0] pix, pix_next;
  logic [1:0] bip, bip_next;

  // Captured header fields and derived lengths
  logic [15:0] sig, planes, depth;
  logic [31:0] fsize, offset, width, height, dlen, diff;
  logic [LINE_W-1:0] region, line_len;
  logic [IMG_W-1:0] img;

  logic accept;
  logic [5:0] hdr_idx;
  logic hdr_last, hdr_fail, depth32, pix_last;
  bmp_pkg::err_t hdr_err;
  logic [DIM_W-1:0] width_d, height_d;

  bmp_pkg::result_t head;
  logic head_valid, tail_valid;
  bmp_pkg::kind_t tail_kind;
  bmp_pkg::err_t tail_err;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign hdr_idx  = hdr_cnt[5:0];
  assign hdr_last = (hdr_cnt == 32'(bmp_pkg::HEADER_BYTES - 1));
  assign depth32  = (depth == bmp_pkg::DEPTH32);
  assign pix_last = (bip == (depth32 ? 2'd3 : 2'd2));
  assign width_d  = width[DIM_W-1:0];
  assign height_d = height[DIM_W-1:0];

  always_comb begin
    hdr_fail = 1'b1;
    hdr_err  = bmp_pkg::E_SIGNATURE;
    if (sig != bmp_pkg::SIG_VALUE) begin
      hdr_err = bmp_pkg::E_SIGNATURE;
    end else if (planes != bmp_pkg::PLANES1) begin
      hdr_err = bmp_pkg::E_PLANES;
    end else if (depth != bmp_pkg::DEPTH24 && depth != bmp_pkg::DEPTH32) begin
      hdr_err = bmp_pkg::E_DEPTH;
    end else if (offset < 32'(bmp_pkg::HEADER_BYTES)) begin
      hdr_err = bmp_pkg::E_OFFSET;
    end else if (width > 32'(MAX_DIM) || height > 32'(MAX_DIM)) begin
      hdr_err = bmp_pkg::E_TOO_LARGE;
    end else begin
      hdr_fail = 1'b0;
    end
  end

  // Header capture and length setup, one step per header byte after capture ends
  always_ff @(posedge clk) begin
    if (accept && phase == bmp_pkg::PH_HEADER) begin
      for (int k = 0; k < 2; k++) begin
        if (hdr_idx == 6'(bmp_pkg::OFS_SIG + k))    sig[8*k +: 8]    <= in_byte;
        if (hdr_idx == 6'(bmp_pkg::OFS_PLANES + k)) planes[8*k +: 8] <= in_byte;
        if (hdr_idx == 6'(bmp_pkg::OFS_DEPTH + k))  depth[8*k +: 8]  <= in_byte;
      end
      for (int k = 0; k < 4; k++) begin
        if (hdr_idx == 6'(bmp_pkg::OFS_FSIZE + k))  fsize[8*k +: 8]  <= in_byte;
        if (hdr_idx == 6'(bmp_pkg::OFS_OFFSET + k)) offset[8*k +: 8] <= in_byte;
        if (hdr_idx == 6'(bmp_pkg::OFS_WIDTH + k))  width[8*k +: 8]  <= in_byte;
        if (hdr_idx == 6'(bmp_pkg::OFS_HEIGHT + k)) height[8*k +: 8] <= in_byte;
        if (hdr_idx == 6'(bmp_pkg::OFS_DLEN + k))   dlen[8*k +: 8]   <= in_byte;
      end
      if (hdr_idx == 6'(bmp_pkg::RECON_IDX)) begin
        region <= depth32 ? {width_d, 2'b00}
                          : LINE_W'({2'b00, width_d} + {1'b0, width_d, 1'b0});
        diff   <= fsize - offset;
      end
      if (hdr_idx == 6'(bmp_pkg::RECON_IDX + 1)) begin
        line_len <= LINE_W'(region + LINE_W'(bmp_pkg::LINE_PAD))
                    & ~LINE_W'(bmp_pkg::LINE_PAD);
        if (diff > dlen) dlen <= diff;
      end
      if (hdr_idx == 6'(bmp_pkg::RECON_IDX + 2)) begin
        img <= IMG_W'(line_len) * IMG_W'(height_d);
      end
      if (hdr_idx == 6'(bmp_pkg::RECON_IDX + 3)) begin
        if (CMP_W'(dlen) > CMP_W'(img)) dlen <= 32'(img);
      end
    end
  end

  always_comb begin
    phase_next    = phase;
    hdr_cnt_next  = hdr_cnt;
    data_cnt_next = data_cnt;
    line_cnt_next = line_cnt;
    column_next   = column;
    file_row_next = file_row;
    pix_next      = pix;
    bip_next      = bip;
    head          = '0;
    head_valid    = 1'b0;
    tail_valid    = 1'b0;
    tail_kind     = bmp_pkg::K_DONE;
    tail_err      = bmp_pkg::E_SIGNATURE;

    case (phase)
      bmp_pkg::PH_HEADER: begin
        hdr_cnt_next = hdr_cnt + 32'd1;
        if (hdr_last) begin
          head_valid = 1'b1;
          if (hdr_fail) begin
            head       = bmp_pkg::make_terminal(bmp_pkg::K_ERROR, hdr_err);
            phase_next = bmp_pkg::PH_FIN;
          end else begin
            head.kind         = bmp_pkg::K_HEADER;
            head.image_width  = width[13:0];
            head.image_height = height[13:0];
            if (offset > 32'(bmp_pkg::HEADER_BYTES)) begin
              phase_next = bmp_pkg::PH_SKIP;
            end else if (dlen == 32'd0) begin
              tail_valid = 1'b1;
              tail_kind  = bmp_pkg::K_DONE;
              phase_next = bmp_pkg::PH_FIN;
            end else begin
              phase_next = bmp_pkg::PH_DATA;
            end
          end
        end
      end
      bmp_pkg::PH_SKIP: begin
        hdr_cnt_next = hdr_cnt + 32'd1;
        if (hdr_cnt_next == offset) begin
          if (dlen == 32'd0) begin
            head_valid = 1'b1;
            head       = bmp_pkg::make_terminal(bmp_pkg::K_DONE, bmp_pkg::E_SIGNATURE);
            phase_next = bmp_pkg::PH_FIN;
          end else begin
            phase_next = bmp_pkg::PH_DATA;
          end
        end
      end
      bmp_pkg::PH_DATA: begin
        if (line_cnt < region) begin
          if (pix_last) begin
            head_valid  = 1'b1;
            head.kind   = bmp_pkg::K_PIXEL;
            head.red    = in_byte;
            head.green  = pix[7:0];
            head.blue   = pix[15:8];
            head.alpha  = depth32 ? pix[23:16] : 8'd0;
            head.column = column;
            head.row    = height[12:0] - 13'd1 - file_row;
            bip_next    = 2'd0;
            pix_next    = 24'd0;
            column_next = column + 13'd1;
          end else begin
            bip_next = bip + 2'd1;
            pix_next = {pix[15:0], in_byte};
          end
        end
        // End of line: drop the padding and advance the file row
        if (line_cnt + LINE_W'(1) == line_len) begin
          line_cnt_next = '0;
          column_next   = 13'd0;
          bip_next      = 2'd0;
          pix_next      = 24'd0;
          file_row_next = file_row + 13'd1;
        end else begin
          line_cnt_next = line_cnt + LINE_W'(1);
        end
        data_cnt_next = data_cnt + 32'd1;
        if (data_cnt_next == dlen) begin
          if (head_valid) begin
            tail_valid = 1'b1;
            tail_kind  = bmp_pkg::K_DONE;
          end else begin
            head_valid = 1'b1;
            head       = bmp_pkg::make_terminal(bmp_pkg::K_DONE, bmp_pkg::E_SIGNATURE);
          end
          phase_next = bmp_pkg::PH_FIN;
        end
      end
      default: begin
      end
    endcase

    if (in_eof) begin
      if (phase_next != bmp_pkg::PH_FIN) begin
        if (head_valid) begin
          tail_valid = 1'b1;
          tail_kind  = bmp_pkg::K_ERROR;
          tail_err   = (phase_next == bmp_pkg::PH_HEADER) ? bmp_pkg::E_SHORT_HEADER
                                                          : bmp_pkg::E_SHORT_DATA;
        end else begin
          head_valid = 1'b1;
          head       = bmp_pkg::make_terminal(bmp_pkg::K_ERROR,
                         (phase_next == bmp_pkg::PH_HEADER) ? bmp_pkg::E_SHORT_HEADER
                                                            : bmp_pkg::E_SHORT_DATA);
        end
      end
      phase_next    = bmp_pkg::PH_HEADER;
      hdr_cnt_next  = 32'd0;
      data_cnt_next = 32'd0;
      line_cnt_next = '0;
      column_next   = 13'd0;
      file_row_next = 13'd0;
      pix_next      = 24'd0;
      bip_next      = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= bmp_pkg::PH_HEADER;
      hdr_cnt  <= 32'd0;
      data_cnt <= 32'd0;
      line_cnt <= '0;
      column   <= 13'd0;
      file_row <= 13'd0;
      pix      <= 24'd0;
      bip      <= 2'd0;
    end else if (accept) begin
      phase    <= phase_next;
      hdr_cnt  <= hdr_cnt_next;
      data_cnt <= data_cnt_next;
      line_cnt <= line_cnt_next;
      column   <= column_next;
      file_row <= file_row_next;
      pix      <= pix_next;
      bip      <= bip_next;
    end
  end

  assign push             = accept && head_valid;
  assign entry.head       = head;
  assign entry.tail_valid = tail_valid;
  assign entry.tail_kind  = tail_kind;
  assign entry.tail_err   = tail_err;

endmodule

`default_nettype wire

// File: rtl/core/bmp_queue.sv
// Short entry queue between the parser front end and the output back end.
// Depends on bmp_pkg.
`default_nettype none

module bmp_queue #(
  parameter int DEPTH = bmp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire bmp_pkg::entry_t  wr_entry,
  input  wire logic             pop,
  output bmp_pkg::entry_t       rd_entry,
  output bmp_pkg::q_status_t    status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bmp_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_entry     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bmp_back.sv
// Back end: drains queue entries into the output register, one result per
// transfer, expanding the end-of-stream result behind an entry. Depends on bmp_pkg.
`default_nettype none

module bmp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bmp_pkg::entry_t    rd_entry,
  input  wire bmp_pkg::q_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bmp_pkg::result_t        out_res
);

  logic load;
  logic tail_pend;
  bmp_pkg::kind_t tail_kind;
  bmp_pkg::err_t tail_err;

  assign load = !out_valid || out_ready;
  assign pop  = load && !tail_pend && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      tail_pend <= 1'b0;
    end else if (load) begin
      if (tail_pend) begin
        out_res   <= bmp_pkg::make_terminal(tail_kind, tail_err);
        out_valid <= 1'b1;
        tail_pend <= 1'b0;
      end else if (!q_status.empty) begin
        out_res   <= rd_entry.head;
        out_valid <= 1'b1;
        tail_pend <= rd_entry.tail_valid;
        tail_kind <= rd_entry.tail_kind;
        tail_err  <= rd_entry.tail_err;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bmp_stream_decoder.sv
// Top level of the streaming BMP decoder: front parser, entry queue, output stage.
// Depends on bmp_pkg, bmp_front, bmp_queue and bmp_back.
// Path: a result passes through the queue and then the output register before it is
// offered on m_axis; a second result from the same byte is expanded in the output
// stage and offered after the first is taken.
// Throughput: one byte per cycle; a result per cycle while m_axis_tready is high.
// s_axis_tready drops only while the queue holds QUEUE_DEPTH entries.
// Reset: rst (synchronous) returns the parser to the header phase, empties the
// queue and drops m_axis_tvalid; there is no clearing pass.
`default_nettype none

module bmp_stream_decoder #(
  parameter int MAX_DIM     = bmp_pkg::MAX_DIM_DEF,
  parameter int QUEUE_DEPTH = bmp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Byte stream in
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
  input  wire logic                        s_axis_tlast,   // end_of_file
  // Result stream out
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [44:32] column,
  // [57:45] row, [71:58] image_width, [85:72] image_height, [88:86] error_code,
  // [95:89] zero
  output logic [bmp_pkg::TDATA_W-1:0]      m_axis_tdata,
  output logic [1:0]                       m_axis_tuser,   // [1:0] kind
  output logic                             m_axis_tlast    // last result of stream
);

  bmp_pkg::entry_t    wr_entry, rd_entry;
  bmp_pkg::q_status_t q_status;
  bmp_pkg::result_t   out_res;
  logic push, pop;

  // Front end: classify each byte and queue whatever results it causes
  bmp_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_eof   (s_axis_tlast),
    .q_status (q_status),
    .push     (push),
    .entry    (wr_entry)
  );

  // Queue: lets the parser keep taking bytes while the output side stalls
  bmp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .status   (q_status)
  );

  // Back end: hold each result in the output register until its transfer
  bmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd_entry  (rd_entry),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {7'd0, out_res.error_code, out_res.image_height,
                         out_res.image_width, out_res.row, out_res.column,
                         out_res.alpha, out_res.blue, out_res.green, out_res.red};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// File: rtl/core/bmp_check.sv
// Port-level checks for bmp_stream_decoder and the bind that attaches them.
// Depends on bmp_pkg and bmp_stream_decoder.
`default_nettype none

module bmp_check (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [bmp_pkg::TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]                  m_axis_tuser,
  input wire logic                        m_axis_tlast
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Errors and done always close a stream
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == bmp_pkg::K_ERROR || m_axis_tuser == bmp_pkg::K_DONE)
      |-> m_axis_tlast)
    else $error("final result without tlast");

  // Pixels and header results never close a stream
  a_mid_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == bmp_pkg::K_PIXEL || m_axis_tuser == bmp_pkg::K_HEADER)
      |-> !m_axis_tlast)
    else $error("tlast on a pixel or header result");

  // Reset empties the output stage
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind bmp_stream_decoder bmp_check u_check (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
